// File: hdl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// Haversine distance and bearing package
// Shared state encoding, register indexes, fixed-point constants and the
// elaboration-time arc tangent table generator.
// ----------------------------------------------------------------------------
package hvd_pkg;

  // Width of the Q30 working values in the CORDIC and product registers.
  localparam int Q_W = 36;
  localparam int FRAC = 30;

  localparam logic [63:0] CORDIC_X0 = 64'd652032874;
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;
  localparam logic [24:0] DIST_MAX = 25'h1FFFFFF;

  // Register index of the radius register in the configuration space.
  localparam logic REG_RADIUS = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROT_PREP,
    ST_ROT_ITER,
    ST_ROT_DONE,
    ST_MUL,
    ST_MUL_WB,
    ST_COMBINE,
    ST_SQRT_PREP,
    ST_SQRT_ITER,
    ST_SQRT_DONE,
    ST_VEC_PREP,
    ST_VEC_ITER,
    ST_VEC_DONE,
    ST_WIDE,
    ST_WIDE_DONE,
    ST_BEAR
  } hvd_state_t;

  // Upper 64 bits of a 64 by 64 product, used for constants only.
  function automatic logic [63:0] mul_hi64(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[127:64];
  endfunction

  // Arc tangent of 2^-i in units of 2^-(ab+1) turn, rounded to nearest.
  function automatic logic [63:0] atan_entry(input int i, input int ab);
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] turns;
    int k;
    int e;
    int sh;
    acc = 64'd0;
    sh = 61 - ab;
    if (i == 0) begin
      return 64'd1 << (ab - 2);
    end
    for (k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    turns = mul_hi64(acc, INV_TWO_PI_Q64);
    return (turns + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// File: hdl/haversine_distance_bearing.sv
// ----------------------------------------------------------------------------
// Haversine distance and initial bearing
// Great-circle distance and initial bearing between two positions, computed
// with one shared CORDIC unit, one shared 32x32 multiplier and a sequencer.
// ----------------------------------------------------------------------------
// Usage: an input transaction carries two positions in binary angle units
// (2^32 is a full turn). It is taken when in_valid is high and in_stall is
// low. in_stall stays high while a pair is being worked on, so the block
// holds one pair at a time. Each pair gives exactly one output transaction
// with distance_m (whole metres, saturating) and bearing_angle.
// The five sine/cosine passes and two vectoring passes through the single
// CORDIC stage set most of the latency. A vectoring pass with a zero y
// input skips its iterations. The block goes back to idle before it takes
// the next pair.
// The result sits in an output register; a new pair is accepted while it
// waits, and the next result waits in the sequencer until out_stall drops.
// Synchronous reset clears the sequencer and output valid and sets the
// radius register to 6371000 m. The radius is written over the APB port at
// byte address 0 and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module haversine_distance_bearing #(
  parameter int ANGLE_BITS = 32,
  parameter int CORDIC_STEPS = 32
) (
  input  logic              clk,
  input  logic              rst,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [31:0] start_latitude,
  input  logic signed [31:0] start_longitude,
  input  logic signed [31:0] end_latitude,
  input  logic signed [31:0] end_longitude,
  // Output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [24:0]       distance_m,
  output logic [31:0]       bearing_angle
);
  import hvd_pkg::*;

  localparam int UW = ANGLE_BITS + 1;
  localparam int ZW = ANGLE_BITS + 2;
  localparam int SW = $clog2(CORDIC_STEPS);
  localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(1) << ANGLE_BITS;
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(1) << (ANGLE_BITS - 1);
  localparam int BSH = ANGLE_BITS + 1 - 32;
  localparam int BSH_R = (BSH > 0) ? BSH : 0;
  localparam int BSH_L = (BSH < 0) ? -BSH : 0;
  localparam logic [63:0] BEAR_RND = (64'd1 << BSH_R) >> 1;
  localparam logic [63:0] DIST_RND = 64'd1 << (ANGLE_BITS - 5);
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC;

  // Arc tangent constants for each CORDIC step.
  logic signed [ZW-1:0] atan_tab [CORDIC_STEPS];
  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_atan
    assign atan_tab[gi] = ZW'(atan_entry(gi, ANGLE_BITS));
  end

  hvd_state_t state, state_next;

  logic [22:0]            radius;
  logic [ANGLE_BITS-1:0]  lat1, lon1, lat2, lon2;
  logic [3:0]             op;
  logic [SW-1:0]          step;
  logic [4:0]             sq_cnt;
  logic [2:0]             wcnt;
  logic signed [Q_W-1:0]  cx, cy;
  logic signed [ZW-1:0]   cz;
  logic                   flip;
  logic signed [Q_W-1:0]  s1, c1, s2, c2, sdl, sdo, sdn, cdn;
  logic signed [Q_W-1:0]  m_a, m_b, m_c, m_d, by, bx;
  logic                   mul_neg;
  logic [63:0]            prod;
  logic [30:0]            a_q;
  logic [63:0]            sq_v, sq_r;
  logic                   bear_pass, bear_add, wide_pass;
  logic [63:0]            wide_a, wide_b;
  logic [127:0]           acc;
  logic [24:0]            dist_q;

  // Combinational datapath signals
  logic [ANGLE_BITS-1:0]  lat1_in, lon1_in, lat2_in, lon2_in;
  logic [ANGLE_BITS-1:0]  dlat, dlon;
  logic [UW-1:0]          rot_ang;
  logic signed [ZW-1:0]   z_pre, z_fold;
  logic                   flip_pre;
  logic signed [Q_W-1:0]  dx, dy;
  logic                   go_neg;
  logic signed [Q_W-1:0]  mq_x, mq_y, abs_x, abs_y;
  logic [31:0]            mul_a, mul_b;
  logic [63:0]            mul_p;
  logic signed [65:0]     prod_s;
  logic signed [Q_W-1:0]  mul_res;
  logic signed [Q_W:0]    a_sum;
  logic [63:0]            sq_bit, sq_try;
  logic signed [Q_W-1:0]  rot_x, rot_y;
  logic signed [ZW-1:0]   phi;
  logic [63:0]            hi, dist_full;
  logic [UW-1:0]          bear_u;
  logic [63:0]            bear_w;
  logic [31:0]            bear_res;
  logic [127:0]           pp_shifted;
  logic                   in_take, out_free;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIUS) ? 32'(radius) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
      radius <= pwdata[22:0];
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_take = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Input angles reduced to ANGLE_BITS by truncation or zero fill.
  assign lat1_in = ANGLE_BITS'({start_latitude, 32'd0} >> (64 - ANGLE_BITS));
  assign lon1_in = ANGLE_BITS'({start_longitude, 32'd0} >> (64 - ANGLE_BITS));
  assign lat2_in = ANGLE_BITS'({end_latitude, 32'd0} >> (64 - ANGLE_BITS));
  assign lon2_in = ANGLE_BITS'({end_longitude, 32'd0} >> (64 - ANGLE_BITS));
  assign dlat = lat2 - lat1;
  assign dlon = lon2 - lon1;

  // Angle for the current sine/cosine pass; differences are used as half angles.
  always_comb begin
    case (op)
      4'd0:    rot_ang = {lat1, 1'b0};
      4'd1:    rot_ang = {lat2, 1'b0};
      4'd2:    rot_ang = {1'b0, dlat};
      4'd3:    rot_ang = {1'b0, dlon};
      default: rot_ang = {dlon, 1'b0};
    endcase
    z_pre = ZW'($signed(rot_ang));
    z_fold = z_pre;
    flip_pre = 1'b0;
    if (z_pre > QUARTER_TURN) begin
      z_fold = z_pre - HALF_TURN;
      flip_pre = 1'b1;
    end else if (z_pre < -QUARTER_TURN) begin
      z_fold = z_pre + HALF_TURN;
      flip_pre = 1'b1;
    end
  end

  // Shared CORDIC stage: rotation drives z to zero, vectoring drives y to zero.
  assign dx = cy >>> step;
  assign dy = cx >>> step;
  assign go_neg = (state == ST_ROT_ITER) ? !cz[ZW-1] : cy[Q_W-1];
  assign rot_x = flip ? -cx : cx;
  assign rot_y = flip ? -cy : cy;

  // Operands of the Q30 products, in sequence order.
  always_comb begin
    case (op)
      4'd0:    begin mq_x = sdl; mq_y = sdl; end
      4'd1:    begin mq_x = c1;  mq_y = c2;  end
      4'd2:    begin mq_x = sdo; mq_y = sdo; end
      4'd3:    begin mq_x = m_b; mq_y = m_c; end
      4'd4:    begin mq_x = sdn; mq_y = c2;  end
      4'd5:    begin mq_x = c1;  mq_y = s2;  end
      4'd6:    begin mq_x = s1;  mq_y = c2;  end
      default: begin mq_x = m_d; mq_y = cdn; end
    endcase
    abs_x = mq_x[Q_W-1] ? -mq_x : mq_x;
    abs_y = mq_y[Q_W-1] ? -mq_y : mq_y;
  end

  // The one multiplier, shared by the Q30 products and the wide distance product.
  always_comb begin
    if (state == ST_WIDE) begin
      mul_a = wcnt[1] ? wide_a[63:32] : wide_a[31:0];
      mul_b = wcnt[0] ? wide_b[63:32] : wide_b[31:0];
    end else begin
      mul_a = abs_x[31:0];
      mul_b = abs_y[31:0];
    end
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign prod_s = mul_neg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
  assign mul_res = Q_W'(prod_s >>> FRAC);
  assign a_sum = (Q_W + 1)'(m_a) + (Q_W + 1)'(m_b);

  always_comb begin
    case (wcnt)
      3'd1:    pp_shifted = {64'd0, prod};
      3'd2:    pp_shifted = {32'd0, prod, 32'd0};
      3'd3:    pp_shifted = {32'd0, prod, 32'd0};
      default: pp_shifted = {prod, 64'd0};
    endcase
  end

  // Restoring square root, two bits of the radicand per cycle.
  assign sq_bit = 64'd1 << (6'd62 - {sq_cnt, 1'b0});
  assign sq_try = sq_r + sq_bit;

  assign phi = cz[ZW-1] ? '0 : cz;
  assign hi = acc[127:64];
  assign dist_full = (hi + DIST_RND) >> (ANGLE_BITS - 4);

  always_comb begin
    bear_u = UW'(cz + (bear_add ? HALF_TURN : ZW'(0)));
    if (BSH > 0) begin
      bear_w = (64'(bear_u) + BEAR_RND) >> BSH_R;
    end else begin
      bear_w = 64'(bear_u) << BSH_L;
    end
    bear_res = bear_w[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_take) state_next = ST_ROT_PREP;
      ST_ROT_PREP:  state_next = ST_ROT_ITER;
      ST_ROT_ITER:  if (step == LAST_STEP) state_next = ST_ROT_DONE;
      ST_ROT_DONE:  state_next = (op == 4'd4) ? ST_MUL : ST_ROT_PREP;
      ST_MUL:       state_next = ST_MUL_WB;
      ST_MUL_WB:    state_next = (op == 4'd7) ? ST_COMBINE : ST_MUL;
      ST_COMBINE:   state_next = ST_SQRT_PREP;
      ST_SQRT_PREP: state_next = ST_SQRT_ITER;
      ST_SQRT_ITER: if (sq_cnt == 5'd31) state_next = ST_SQRT_DONE;
      ST_SQRT_DONE: state_next = (op == 4'd1) ? ST_VEC_PREP : ST_SQRT_PREP;
      ST_VEC_PREP:  state_next = (cy == '0) ? ST_VEC_DONE : ST_VEC_ITER;
      ST_VEC_ITER:  if (step == LAST_STEP) state_next = ST_VEC_DONE;
      ST_VEC_DONE: begin
        if (!bear_pass) begin
          state_next = ST_WIDE;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_WIDE:      if (wcnt == 3'd4) state_next = ST_WIDE_DONE;
      ST_WIDE_DONE: state_next = wide_pass ? ST_BEAR : ST_WIDE;
      ST_BEAR:      state_next = ST_VEC_PREP;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_VEC_DONE && bear_pass && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          lat1 <= lat1_in;
          lon1 <= lon1_in;
          lat2 <= lat2_in;
          lon2 <= lon2_in;
          op <= 4'd0;
          bear_pass <= 1'b0;
        end
      end
      ST_ROT_PREP: begin
        cx <= Q_W'(CORDIC_X0);
        cy <= '0;
        cz <= z_fold;
        flip <= flip_pre;
        step <= '0;
      end
      ST_ROT_ITER, ST_VEC_ITER: begin
        if (go_neg) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - atan_tab[step];
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + atan_tab[step];
        end
        step <= step + 1'b1;
      end
      ST_ROT_DONE: begin
        case (op)
          4'd0:    begin s1 <= rot_y; c1 <= rot_x; end
          4'd1:    begin s2 <= rot_y; c2 <= rot_x; end
          4'd2:    sdl <= rot_y;
          4'd3:    sdo <= rot_y;
          default: begin sdn <= rot_y; cdn <= rot_x; end
        endcase
        op <= (op == 4'd4) ? 4'd0 : op + 4'd1;
      end
      ST_MUL: begin
        prod <= mul_p;
        mul_neg <= mq_x[Q_W-1] ^ mq_y[Q_W-1];
      end
      ST_MUL_WB: begin
        case (op)
          4'd0:    m_a <= mul_res;
          4'd1:    m_b <= mul_res;
          4'd2:    m_c <= mul_res;
          4'd3:    m_b <= mul_res;
          4'd4:    by <= mul_res;
          4'd5:    m_c <= mul_res;
          default: m_d <= mul_res;
        endcase
        op <= (op == 4'd7) ? 4'd0 : op + 4'd1;
      end
      ST_COMBINE: begin
        if (a_sum[Q_W]) begin
          a_q <= '0;
        end else if (a_sum > (Q_W + 1)'(ONE_Q)) begin
          a_q <= 31'(ONE_Q);
        end else begin
          a_q <= a_sum[30:0];
        end
        bx <= m_c - m_d;
      end
      ST_SQRT_PREP: begin
        sq_v <= (op == 4'd0) ? (ONE_Q - 64'(a_q)) << FRAC : 64'(a_q) << FRAC;
        sq_r <= '0;
        sq_cnt <= '0;
      end
      ST_SQRT_ITER: begin
        if (sq_v >= sq_try) begin
          sq_v <= sq_v - sq_try;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_cnt <= sq_cnt + 5'd1;
      end
      ST_SQRT_DONE: begin
        if (op == 4'd0) begin
          cx <= Q_W'(sq_r);
          op <= 4'd1;
        end else begin
          cy <= Q_W'(sq_r);
          op <= 4'd0;
        end
      end
      ST_VEC_PREP: begin
        cz <= '0;
        step <= '0;
      end
      ST_VEC_DONE: begin
        if (!bear_pass) begin
          wide_a <= 64'(unsigned'(phi));
          wide_b <= 64'(radius);
          acc <= '0;
          wcnt <= '0;
          wide_pass <= 1'b0;
        end else if (out_free) begin
          distance_m <= dist_q;
          bearing_angle <= bear_res;
        end
      end
      ST_WIDE: begin
        if (wcnt != 3'd4) begin
          prod <= mul_p;
        end
        if (wcnt != 3'd0) begin
          acc <= acc + pp_shifted;
        end
        wcnt <= wcnt + 3'd1;
      end
      ST_WIDE_DONE: begin
        if (!wide_pass) begin
          wide_a <= acc[63:0];
          wide_b <= TWO_PI_Q60;
          acc <= '0;
          wcnt <= '0;
          wide_pass <= 1'b1;
        end else begin
          dist_q <= (dist_full[63:25] != '0) ? DIST_MAX : dist_full[24:0];
        end
      end
      ST_BEAR: begin
        if (bx[Q_W-1]) begin
          cx <= -bx;
          cy <= -by;
          bear_add <= 1'b1;
        end else begin
          cx <= bx;
          cy <= by;
          bear_add <= 1'b0;
        end
        bear_pass <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // An accepted pair always starts with the first sine/cosine pass.
  assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == ST_ROT_PREP && op == 4'd0)
    else $error("accepted pair did not start the first CORDIC pass");

  // The haversine term is clamped to [0, 1] before the square roots.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SQRT_PREP |-> 64'(a_q) <= ONE_Q)
    else $error("haversine term out of range");

  // A root of a Q60 value at most one is at most one in Q30.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SQRT_DONE |-> sq_r <= ONE_Q)
    else $error("square root result too large");

  // New results are only loaded from the final vectoring pass.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_VEC_DONE && $past(bear_pass))
    else $error("output loaded outside the bearing pass");

  // Sine/cosine passes never run past the last angle.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_ROT_ITER |-> op <= 4'd4)
    else $error("sine/cosine pass index out of range");

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Haversine distance and bearing testbench
// Sends position pairs through the valid/stall input channel. Each pair is
// predicted in fixed point with a CORDIC of its own, and every output
// transaction is checked against the oldest prediction. The radius register
// is rewritten over APB between phases. Both channels idle at random, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import hvd_pkg::*;

  localparam int STEPS = 32;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam logic [63:0] TURN_MASK = 64'h1_FFFF_FFFF;  // 2^-33 turn units
  localparam logic [63:0] BAM_MASK = 64'hFFFF_FFFF;
  localparam logic [2:0] ADDR_RADIUS = 3'(4 * REG_RADIUS);
  // Byte address with no register behind it; a write there must change nothing.
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES = 3000;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic signed [31:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [31:0] lat_b;
    logic signed [31:0] lon_b;
  } fix_pair_t;

  typedef struct packed {
    logic [24:0] range_m;
    logic [31:0] bearing;
  } course_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] start_latitude = '0, start_longitude = '0;
  logic signed [31:0] end_latitude = '0, end_longitude = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [24:0] distance_m;
  logic [31:0] bearing_angle;

  haversine_distance_bearing dut (.*);

  always #10 clk = ~clk;

  // Arc tangent of 2^-i in units of 2^-33 turn.
  longint atan_q[STEPS];
  logic [22:0] radius_now = RADIUS_RESET;

  fix_pair_t pending_fixes[$];
  course_t courses_due[$];
  int errors = 0;
  int pairs_sent = 0;
  int courses_seen = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int in_gap = 0;
  int out_gap = 0;
  longint cycles = 0;

  function automatic void build_atan();
    logic [63:0] acc, term, turns;
    logic [127:0] prod;
    int e;
    atan_q[0] = 64'sd1 << 30;
    for (int i = 1; i < STEPS; i++) begin
      acc = 0;
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
          acc = (k % 2) ? acc - term : acc + term;
        end
      end
      prod = 128'(acc) * 128'(INV_TWO_PI_Q64);
      turns = prod[127:64];
      atan_q[i] = longint'((turns + (64'd1 << 28)) >> 29);
    end
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  // Rotation CORDIC: sine and cosine (Q30) of an angle in 2^-33 turn units.
  function automatic void rot_sincos(input logic [63:0] ang, output longint s,
                                     output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang & TURN_MASK);
    x = longint'(CORDIC_X0);
    y = 0;
    flip = 0;
    if (z >= (64'sd1 << 32)) z -= 64'sd1 << 33;
    if (z > (64'sd1 << 31)) begin
      z -= 64'sd1 << 32;
      flip = 1;
    end else if (z < -(64'sd1 << 31)) begin
      z += 64'sd1 << 32;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_q[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_q[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Vectoring CORDIC: angle of (x, y) for x >= 0.
  function automatic longint vec_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    if (y == 0) return 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx;
        y += dy;
        z -= atan_q[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_q[i];
      end
    end
    return z;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic course_t plot_course(fix_pair_t p, logic [22:0] radius);
    logic [63:0] la1, lo1, la2, lo2, dlat, dlon, t, hi, dist_raw, r;
    logic [127:0] wide;
    longint s1, c1, s2, c2, sdl, sdo, sdn, cdn, spare, a, phi, bx, by, z, add;
    course_t res;
    la1 = 64'(p.lat_a) & BAM_MASK;
    lo1 = 64'(p.lon_a) & BAM_MASK;
    la2 = 64'(p.lat_b) & BAM_MASK;
    lo2 = 64'(p.lon_b) & BAM_MASK;
    dlat = (la2 - la1) & BAM_MASK;
    dlon = (lo2 - lo1) & BAM_MASK;
    rot_sincos(la1 << 1, s1, c1);
    rot_sincos(la2 << 1, s2, c2);
    // Plain differences are already half angles in the finer units.
    rot_sincos(dlat, sdl, spare);
    rot_sincos(dlon, sdo, spare);
    rot_sincos(dlon << 1, sdn, cdn);
    a = qmul(sdl, sdl) + qmul(qmul(c1, c2), qmul(sdo, sdo));
    if (a < 0) a = 0;
    if (a > ONE_Q30) a = ONE_Q30;
    phi = vec_angle(longint'(floor_sqrt(64'(ONE_Q30 - a) << 30)),
                    longint'(floor_sqrt(64'(a) << 30)));
    if (phi < 0) phi = 0;
    t = 64'(phi) * 64'(radius);
    wide = 128'(t) * 128'(TWO_PI_Q60);
    hi = wide[127:64];
    dist_raw = (hi + (64'd1 << 27)) >> 28;
    if (dist_raw > 64'(DIST_MAX)) dist_raw = 64'(DIST_MAX);
    by = qmul(sdn, c2);
    bx = qmul(c1, s2) - qmul(qmul(s1, c2), cdn);
    add = 0;
    // A southward course is turned by half a turn so the vectoring stays in range.
    if (bx < 0) begin
      bx = -bx;
      by = -by;
      add = 64'sd1 << 32;
    end
    z = vec_angle(bx, by) + add;
    r = ((64'(z) & TURN_MASK) + 64'd1) >> 1;
    res.range_m = dist_raw[24:0];
    res.bearing = r[31:0];
    return res;
  endfunction

  // Sender. A payload that is stalled is held; otherwise the next pending
  // pair goes out unless a random gap is running.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        courses_due.push_back(plot_course({start_latitude, start_longitude,
                                           end_latitude, end_longitude}, radius_now));
        pairs_sent++;
      end
      if (in_valid && in_stall) begin
        // Hold the current transaction until it is taken.
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else if (pending_fixes.size() > 0) begin
        fix_pair_t f;
        f = pending_fixes.pop_front();
        start_latitude <= f.lat_a;
        start_longitude <= f.lon_a;
        end_latitude <= f.lat_b;
        end_longitude <= f.lon_b;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering pairs
  // and the block backs up into its input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Receiver: checks each output transaction and stalls in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        course_t want;
        courses_seen++;
        if (courses_due.size() == 0) begin
          $display("%0t: unexpected result dist %0d bearing %h", $time,
                   distance_m, bearing_angle);
          errors++;
        end else begin
          want = courses_due.pop_front();
          if (distance_m !== want.range_m) begin
            $display("%0t: distance_m expected %0d actual %0d", $time, want.range_m,
                     distance_m);
            errors++;
          end
          if (bearing_angle !== want.bearing) begin
            $display("%0t: bearing_angle expected %h actual %h", $time,
                     want.bearing, bearing_angle);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap <= $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_RADIUS) radius_now = data[22:0];
  endtask

  // Waits until every sent pair has produced its result, then lets the
  // sequencer settle before the register may change.
  task automatic drain();
    @(negedge clk);
    while (pending_fixes.size() > 0 || in_valid || courses_due.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] any_lat();
    case ($urandom_range(0, 9))
      0: return $urandom;  // may fall outside +-90 degrees
      1: return 32'sh4000_0000 - 32'($urandom_range(0, 4000));
      2: return -32'sh4000_0000 + 32'($urandom_range(0, 4000));
      default: return 32'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endcase
  endfunction

  task automatic add_random(int n);
    fix_pair_t f;
    repeat (n) begin
      f.lat_a = any_lat();
      f.lon_a = $urandom;
      case ($urandom_range(0, 3))
        0: begin  // a nearby point
          f.lat_b = f.lat_a + 32'($signed(16'($urandom)));
          f.lon_b = f.lon_a + 32'($signed(20'($urandom)));
        end
        1: begin  // near the antipode
          f.lat_b = -f.lat_a + 32'($urandom_range(0, 255));
          f.lon_b = f.lon_a + 32'sh8000_0000 + 32'($signed(12'($urandom)));
        end
        default: begin
          f.lat_b = any_lat();
          f.lon_b = $urandom;
        end
      endcase
      pending_fixes.push_back(f);
    end
  endtask

  initial begin
    logic [22:0] radius_list[5];
    build_atan();
    radius_list = '{23'd1, 23'd8000000, 23'd0, 23'h7FFFFF, 23'd6371000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed pairs at the reset radius: coincident points, poles, field
    // extremes, antipodes, latitudes beyond the pole and due-south courses.
    pending_fixes.push_back('{0, 0, 0, 0});
    pending_fixes.push_back('{32'sh4000_0000, 0, 32'sh4000_0000, 32'sh1234_5678});
    pending_fixes.push_back('{-32'sh4000_0000, 0, 32'sh4000_0000, 0});
    pending_fixes.push_back('{0, 32'sh8000_0000, 0, 32'sh7FFF_FFFF});
    pending_fixes.push_back('{0, 0, 0, 32'sh8000_0000});
    pending_fixes.push_back('{32'sh1000_0000, 32'sh1000_0000, -32'sh1000_0000,
                              -32'sh7000_0000});
    pending_fixes.push_back('{32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0});
    pending_fixes.push_back('{-1, -1, -1, -1});
    pending_fixes.push_back('{32'sh1000_0000, 0, -32'sh1000_0000, 0});
    pending_fixes.push_back('{0, 0, 32'sh1000_0000, 0});
    pending_fixes.push_back('{0, 0, 0, 32'sh4000_0000});
    pending_fixes.push_back('{0, 0, 0, -32'sh4000_0000});
    pending_fixes.push_back('{32'sh2000_0000, 32'sh7FFF_FFFF, 32'sh2000_0001,
                              32'sh8000_0000});
    pending_fixes.push_back('{32'sh4000_0001, 32'sh5555_5555, -32'sh4000_0001,
                              32'shAAAA_AAAA});
    pending_fixes.push_back('{0, 0, 1, 1});
    hold_go = 1'b1;
    add_random(150);
    drain();

    // An address with no register behind it must leave the radius alone.
    apb_write(ADDR_UNUSED, 32'd12345);
    add_random(40);
    drain();

    foreach (radius_list[i]) begin
      apb_write(ADDR_RADIUS, 32'(radius_list[i]));
      add_random(160);
      drain();
    end

    apb_write(ADDR_RADIUS, 32'($urandom_range(1, 8000000)));
    quiet = 1'b1;
    add_random(200);
    drain();

    $display("tb: %0d position pairs sent, %0d results checked, %0d mismatches",
             pairs_sent, courses_seen, errors);
    $display("tb: radius settings 1, 8000000, 0, 8388607, reset and random values");
    if (errors == 0 && courses_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/hvd_pkg.sv
hdl/haversine_distance_bearing.sv
test/testbench.sv
